// File: rtl/core/gzrp_pkg.sv
// ----------------------------------------------------------------------------
// gzrp_pkg: shared definitions for the gaze region run packetizer
// Widths, register indexes, controller states and the command and status
// structures that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package gzrp_pkg;

  localparam int DEF_TUPLES_PER_PACKET = 20;
  localparam int DEF_MAX_REGIONS       = 6;
  localparam int NUM_RECTS             = 6;

  localparam int COORD_W    = 16;
  localparam int TIME_W     = 31;
  localparam int REGION_W   = 3;
  localparam int END_W      = 32;
  localparam int INTERVAL_W = 16;
  localparam int RECT_W     = 64;
  localparam int TUPLE_W    = REGION_W + TIME_W + END_W;

  localparam int S_TDATA_W  = 64;
  localparam int M_TDATA_W  = 72;

  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 64;

  localparam logic [CFG_IDX_W-1:0] CFG_REGION_COUNT = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL     = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RECT_FIRST   = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RECT_LAST    = 4'd7;

  localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 16'd10;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_READ,
    ST_SEND
  } gzrp_state_e;

  typedef struct packed {
    logic capture;
    logic eval;
    logic read;
    logic advance;
  } gzrp_cmd_t;

  typedef struct packed {
    logic fill_done;
    logic last_beat;
  } gzrp_sts_t;

endpackage

// File: rtl/core/gaze_roi_run_packetizer_top.sv
// ----------------------------------------------------------------------------
// gaze_roi_run_packetizer_top: gaze region run packetizer
// Matches gaze samples to rectangles, merges runs into tuples and sends
// full packets of tuples on an output stream.
// ----------------------------------------------------------------------------
// Usage:
// Samples enter on the s_axis stream, one per beat. Each is tested against
// the configured rectangles; the first one that holds the point gives the
// region. Unmatched samples are dropped. Matched samples either extend the
// current run or open a new tuple in a store of TUPLES_PER_PACKET entries.
// An accepted sample is captured, then matched and written to the store;
// no sample is accepted while that match and store update is under way.
// When the store fills, the whole packet goes out on m_axis, one tuple per
// beat, tlast on the final beat. Each beat is a read of the store memory
// followed by the beat itself, which waits while m_axis stalls; no sample
// is accepted until the packet is gone.
// Configuration is written through cfg_we_i/cfg_idx_i/cfg_data_i while idle.
// Reset empties the store and restores the register defaults.
// ----------------------------------------------------------------------------
module gaze_roi_run_packetizer_top
  import gzrp_pkg::*;
#(
  parameter int TUPLES_PER_PACKET = DEF_TUPLES_PER_PACKET,
  parameter int MAX_REGIONS       = DEF_MAX_REGIONS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // Fields from bit 0: gaze_x[15:0], gaze_y[31:16], sample_time[62:32], zero.
  input  logic [S_TDATA_W-1:0]  s_axis_tdata,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // Fields from bit 0: region_index[2:0], start_ms[33:3], end_ms[65:34], zeros.
  output logic [M_TDATA_W-1:0]  m_axis_tdata,
  output logic                  m_axis_tlast
);

  gzrp_cmd_t cmd;
  gzrp_sts_t sts;

  gzrp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  gzrp_datapath #(
    .TUPLES_PER_PACKET (TUPLES_PER_PACKET),
    .MAX_REGIONS       (MAX_REGIONS)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_data_i  (s_axis_tdata),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_data_o (m_axis_tdata),
    .out_last_o (m_axis_tlast)
  );

endmodule

// File: rtl/core/gzrp_ram.sv
// ----------------------------------------------------------------------------
// gzrp_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle. Contents are not reset.
// ----------------------------------------------------------------------------
module gzrp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/gzrp_ctrl.sv
// ----------------------------------------------------------------------------
// gzrp_ctrl: sequencing state machine
// Accepts one sample, evaluates it, and when the store is full walks the
// stored tuples out one beat at a time.
// ----------------------------------------------------------------------------
module gzrp_ctrl
  import gzrp_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  input  gzrp_sts_t sts_i,
  output gzrp_cmd_t cmd_o
);

  gzrp_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_EVAL;
      end
      ST_EVAL: begin
        state_d = sts_i.fill_done ? ST_READ : ST_IDLE;
      end
      ST_READ: begin
        state_d = ST_SEND;
      end
      ST_SEND: begin
        if (out_ready_i) state_d = sts_i.last_beat ? ST_IDLE : ST_READ;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o    = 1'b0;
    out_valid_o   = 1'b0;
    cmd_o         = '0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      ST_EVAL: begin
        cmd_o.eval = 1'b1;
      end
      ST_READ: begin
        cmd_o.read = 1'b1;
      end
      ST_SEND: begin
        out_valid_o   = 1'b1;
        cmd_o.advance = out_ready_i;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

endmodule

// File: rtl/core/gzrp_datapath.sv
// ----------------------------------------------------------------------------
// gzrp_datapath: region match, run merge and tuple store
// Holds the configuration registers, the captured sample, the last tuple,
// the tuple store and the read pointer for packet output.
// ----------------------------------------------------------------------------
module gzrp_datapath
  import gzrp_pkg::*;
#(
  parameter int TUPLES_PER_PACKET = DEF_TUPLES_PER_PACKET,
  parameter int MAX_REGIONS       = DEF_MAX_REGIONS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic [S_TDATA_W-1:0]  in_data_i,
  input  gzrp_cmd_t             cmd_i,
  output gzrp_sts_t             sts_o,
  output logic [M_TDATA_W-1:0]  out_data_o,
  output logic                  out_last_o
);

  localparam int AW = (TUPLES_PER_PACKET > 1) ? $clog2(TUPLES_PER_PACKET) : 1;
  localparam int CW = $clog2(TUPLES_PER_PACKET + 1);
  localparam logic [CW-1:0] LAST_IDX = CW'(TUPLES_PER_PACKET - 1);
  localparam logic [REGION_W-1:0] MAX_REG = REGION_W'(MAX_REGIONS);

  function automatic logic in_rect(logic [RECT_W-1:0] b, logic [COORD_W-1:0] x,
                                   logic [COORD_W-1:0] y);
    return (x >= b[15:0]) && (x <= b[47:32]) && (y >= b[31:16]) && (y <= b[63:48]);
  endfunction

  logic [REGION_W-1:0]   region_count_q;
  logic [INTERVAL_W-1:0] interval_q;
  logic [RECT_W-1:0]     rect_q [NUM_RECTS];

  logic [COORD_W-1:0]    x_q, y_q;
  logic [TIME_W-1:0]     t_q;

  logic [REGION_W-1:0]   last_region_q, last_region_d;
  logic [TIME_W-1:0]     last_start_q, last_start_d;
  logic [END_W-1:0]      last_end_q, last_end_d;
  logic [CW-1:0]         count_q, count_d;
  logic [CW-1:0]         rd_ptr_q, rd_ptr_d;

  logic [REGION_W-1:0]   n_eff;
  logic [REGION_W-1:0]   region;
  logic                  hit, merge, wr_en;
  logic                  fill_done, last_beat;
  logic [END_W-1:0]      new_end;
  logic [CW-1:0]         wr_idx;
  logic [TUPLE_W-1:0]    wr_data, rd_data;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      region_count_q <= '0;
      interval_q     <= INTERVAL_RESET;
      for (int i = 0; i < NUM_RECTS; i++) rect_q[i] <= '0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_REGION_COUNT) begin
        region_count_q <= cfg_data_i[REGION_W-1:0];
      end else if (cfg_idx_i == CFG_INTERVAL) begin
        interval_q <= cfg_data_i[INTERVAL_W-1:0];
      end else if (cfg_idx_i >= CFG_RECT_FIRST && cfg_idx_i <= CFG_RECT_LAST) begin
        for (int i = 0; i < NUM_RECTS; i++) begin
          if (cfg_idx_i == CFG_RECT_FIRST + CFG_IDX_W'(i)) rect_q[i] <= cfg_data_i;
        end
      end
    end
  end

  // Sample capture.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      x_q <= in_data_i[15:0];
      y_q <= in_data_i[31:16];
      t_q <= in_data_i[62:32];
    end
  end

  // Region match: the lowest matching rectangle wins.
  always_comb begin
    n_eff  = (region_count_q > MAX_REG) ? MAX_REG : region_count_q;
    region = '0;
    for (int r = MAX_REGIONS - 1; r >= 0; r--) begin
      if (REGION_W'(r) < n_eff && in_rect(rect_q[r], x_q, y_q)) region = REGION_W'(r + 1);
    end
  end

  always_comb begin
    hit     = (region != '0);
    new_end = {1'b0, t_q} + {{(END_W-INTERVAL_W){1'b0}}, interval_q};
    merge   = (count_q != '0) && (region == last_region_q) && ({1'b0, t_q} <= last_end_q);
    wr_en   = cmd_i.eval && hit;
    wr_idx  = merge ? (count_q - CW'(1)) : count_q;

    last_region_d = last_region_q;
    last_start_d  = last_start_q;
    last_end_d    = last_end_q;
    count_d       = count_q;
    fill_done     = 1'b0;
    if (wr_en) begin
      last_end_d = new_end;
      if (!merge) begin
        last_region_d = region;
        last_start_d  = t_q;
        if (count_q == LAST_IDX) begin
          count_d   = '0;
          fill_done = 1'b1;
        end else begin
          count_d = count_q + CW'(1);
        end
      end
    end
    wr_data = {last_end_d, last_start_d, last_region_d};
  end

  always_ff @(posedge clk_i) begin
    last_region_q <= last_region_d;
    last_start_q  <= last_start_d;
    last_end_q    <= last_end_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      rd_ptr_q <= '0;
    end else begin
      count_q  <= count_d;
      rd_ptr_q <= rd_ptr_d;
    end
  end

  assign last_beat = (rd_ptr_q == LAST_IDX);

  always_comb begin
    rd_ptr_d = rd_ptr_q;
    if (cmd_i.advance) begin
      rd_ptr_d = last_beat ? '0 : (rd_ptr_q + CW'(1));
    end
  end

  assign sts_o = '{fill_done: fill_done, last_beat: last_beat};

  gzrp_ram #(
    .WIDTH (TUPLE_W),
    .DEPTH (TUPLES_PER_PACKET)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_idx[AW-1:0]),
    .wdata_i (wr_data),
    .re_i    (cmd_i.read),
    .raddr_i (rd_ptr_q[AW-1:0]),
    .rdata_o (rd_data)
  );

  assign out_data_o = {{(M_TDATA_W-TUPLE_W){1'b0}}, rd_data};
  assign out_last_o = last_beat;

endmodule

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for the gaze region run packetizer
// Gaze samples go in on the input stream and the run tuples that come back
// are checked field by field against a predictor kept in the bench. The
// predictor holds its own copy of the registers and the tuple store.
// Directed cases cover the register defaults, the field extremes, overlapping
// and inverted rectangles, the interval extremes and ignored register writes.
// Random phases follow with different configurations and idle patterns, and
// one phase holds off the output long enough to stall the input.
// ----------------------------------------------------------------------------
module tb
  import gzrp_pkg::*;
();

  localparam int TUPLES = DEF_TUPLES_PER_PACKET;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED = CFG_RECT_LAST + 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_TOP    = '1;

  typedef struct {
    logic [REGION_W-1:0] region_index;
    logic [TIME_W-1:0]   start_ms;
    logic [END_W-1:0]    end_ms;
    logic                packet_last;
  } run_tuple_t;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i     = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i    = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  // Fields from bit 0: gaze_x[15:0], gaze_y[31:16], sample_time[62:32], zero.
  logic [S_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  // Fields from bit 0: region_index[2:0], start_ms[33:3], end_ms[65:34], zeros.
  logic [M_TDATA_W-1:0]  m_axis_tdata;
  logic                  m_axis_tlast;

  logic [REGION_W-1:0]   region_count_cfg;
  logic [INTERVAL_W-1:0] interval_cfg;
  logic [RECT_W-1:0]     rect_cfg [NUM_RECTS];
  run_tuple_t            run_store [TUPLES];
  int                    stored_count;
  run_tuple_t            expected_runs [$];

  int                    mismatches     = 0;
  int                    send_idle_pct  = 0;
  int                    recv_stall_pct = 0;
  int                    hold_cycles    = 0;
  logic [TIME_W-1:0]     cur_time;

  gaze_roi_run_packetizer_top DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #4 clk_i = ~clk_i;

  function automatic logic [RECT_W-1:0] make_rect(input int xmin, input int ymin,
                                                  input int xmax, input int ymax);
    return {16'(ymax), 16'(xmax), 16'(ymin), 16'(xmin)};
  endfunction

  function automatic int active_regions();
    return (region_count_cfg > DEF_MAX_REGIONS) ? DEF_MAX_REGIONS : int'(region_count_cfg);
  endfunction

  function automatic logic [REGION_W-1:0] region_of(input logic [COORD_W-1:0] x,
                                                    input logic [COORD_W-1:0] y);
    logic [RECT_W-1:0] b;
    for (int r = 0; r < active_regions(); r++) begin
      b = rect_cfg[r];
      if (x >= b[15:0] && x <= b[47:32] && y >= b[31:16] && y <= b[63:48]) begin
        return REGION_W'(r + 1);
      end
    end
    return '0;
  endfunction

  function automatic void predict_runs(input logic [COORD_W-1:0] x,
                                       input logic [COORD_W-1:0] y,
                                       input logic [TIME_W-1:0] t);
    logic [REGION_W-1:0] region;
    logic [END_W-1:0]    stop;
    run_tuple_t          tup;
    region = region_of(x, y);
    if (region == '0) return;
    stop = {1'b0, t} + {16'b0, interval_cfg};
    if (stored_count > 0 && run_store[stored_count-1].region_index == region &&
        {1'b0, t} <= run_store[stored_count-1].end_ms) begin
      run_store[stored_count-1].end_ms = stop;
      return;
    end
    run_store[stored_count] = '{region, t, stop, 1'b0};
    stored_count++;
    if (stored_count == TUPLES) begin
      for (int k = 0; k < TUPLES; k++) begin
        tup = run_store[k];
        tup.packet_last = (k == TUPLES - 1);
        expected_runs.insert(expected_runs.size(), tup);
      end
      stored_count = 0;
    end
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    case (idx)
      CFG_REGION_COUNT: region_count_cfg = data[REGION_W-1:0];
      CFG_INTERVAL:     interval_cfg = data[INTERVAL_W-1:0];
      default: begin
        if (idx >= CFG_RECT_FIRST && idx <= CFG_RECT_LAST) begin
          rect_cfg[idx - CFG_RECT_FIRST] = data;
        end
      end
    endcase
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_gaze(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                           input logic [TIME_W-1:0] t);
    if ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, t, y, x};
    do @(posedge clk_i); while (!s_axis_tready);
    predict_runs(x, y, t);
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (expected_runs.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  function automatic logic [RECT_W-1:0] random_rect();
    int x0, y0, x1, y1;
    x0 = $urandom_range(65535);
    y0 = $urandom_range(65535);
    case ($urandom_range(9))
      0: return make_rect(x0 | 16'h8000, y0, x0 & 16'h7FFF, 65535);
      1: return make_rect(0, 0, 65535, 65535);
      default: begin
        x1 = x0 + $urandom_range(6000);
        y1 = y0 + $urandom_range(6000);
        return make_rect(x0, y0, (x1 > 65535) ? 65535 : x1, (y1 > 65535) ? 65535 : y1);
      end
    endcase
  endfunction

  task automatic point_in_rect(input int r, output logic [COORD_W-1:0] x,
                               output logic [COORD_W-1:0] y);
    logic [RECT_W-1:0] b;
    b = rect_cfg[r];
    if (b[15:0] <= b[47:32] && b[31:16] <= b[63:48]) begin
      x = COORD_W'($urandom_range(b[47:32], b[15:0]));
      y = COORD_W'($urandom_range(b[63:48], b[31:16]));
    end else begin
      x = COORD_W'($urandom);
      y = COORD_W'($urandom);
    end
  endtask

  always @(posedge clk_i) begin
    if (hold_cycles != 0) begin
      m_axis_tready <= 1'b0;
      hold_cycles   <= hold_cycles - 1;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    run_tuple_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_runs.size() == 0) begin
        $error("unexpected beat: tdata %h tlast %b", m_axis_tdata, m_axis_tlast);
        mismatches++;
      end else begin
        want = expected_runs.pop_front();
        if (m_axis_tdata[2:0] !== want.region_index) begin
          $error("region_index: expected %0d, got %0d", want.region_index, m_axis_tdata[2:0]);
          mismatches++;
        end
        if (m_axis_tdata[33:3] !== want.start_ms) begin
          $error("start_ms: expected %0d, got %0d", want.start_ms, m_axis_tdata[33:3]);
          mismatches++;
        end
        if (m_axis_tdata[65:34] !== want.end_ms) begin
          $error("end_ms: expected %0d, got %0d", want.end_ms, m_axis_tdata[65:34]);
          mismatches++;
        end
        if (m_axis_tlast !== want.packet_last) begin
          $error("packet_last: expected %0d, got %0d", want.packet_last, m_axis_tlast);
          mismatches++;
        end
      end
    end
  end

  // With no regions in use after reset, every sample is dropped.
  task automatic test_reset_defaults();
    send_gaze(16'h0000, 16'h0000, 31'd0);
    send_gaze(16'hFFFF, 16'hFFFF, 31'h7FFF_FFFF);
    send_gaze(16'h5555, 16'hAAAA, 31'h2AAA_AAAA);
    send_gaze(16'hAAAA, 16'h5555, 31'h5555_5555);
  endtask

  task automatic test_directed_cases();
    wait_idle();
    // Upper bits are ignored, and a count above six means all six regions.
    write_reg(CFG_REGION_COUNT, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(CFG_INTERVAL, 64'hFFFF_FFFF_FFFF_0000);
    write_reg(CFG_RECT_FIRST + 4'd0, make_rect(100, 100, 199, 199));
    write_reg(CFG_RECT_FIRST + 4'd1, make_rect(500, 0, 400, 65535));
    write_reg(CFG_RECT_FIRST + 4'd2, make_rect(150, 150, 300, 300));
    write_reg(CFG_RECT_FIRST + 4'd3, make_rect(0, 0, 0, 0));
    write_reg(CFG_RECT_FIRST + 4'd4, make_rect(65535, 65535, 65535, 65535));
    write_reg(CFG_RECT_FIRST + 4'd5, make_rect(0, 0, 65535, 65535));
    write_reg(CFG_IDX_UNUSED, 64'd0);
    write_reg(CFG_IDX_TOP, 64'd0);
    send_gaze(16'd100, 16'd100, 31'd0);
    send_gaze(16'd199, 16'd199, 31'd0);
    send_gaze(16'd450, 16'd10, 31'd1);
    send_gaze(16'd150, 16'd150, 31'd1);
    send_gaze(16'd250, 16'd250, 31'd2);
    send_gaze(16'd0, 16'd0, 31'd3);
    send_gaze(16'hFFFF, 16'hFFFF, 31'd4);
    send_gaze(16'd300, 16'd301, 31'd5);
    send_gaze(16'd200, 16'd100, 31'd6);
    wait_idle();
    write_reg(CFG_INTERVAL, 64'h0000_0000_0000_FFFF);
    send_gaze(16'd120, 16'd120, 31'd1000);
    send_gaze(16'd130, 16'd130, 31'd66535);
    send_gaze(16'd130, 16'd130, 31'd70000);
    for (int k = 0; k < 11; k++) begin
      send_gaze((k % 2) ? 16'hFFFF : 16'h0000, 16'h0000, 31'h7FFF_FFF5 + 31'(k));
    end
  endtask

  task automatic test_random_phase(input int idle_pct, input int stall_pct, input int n_items,
                                   input logic [CFG_DATA_W-1:0] count_value,
                                   input logic [CFG_DATA_W-1:0] interval_value);
    logic [COORD_W-1:0] x, y;
    int sent, r, run_len;
    wait_idle();
    write_reg(CFG_REGION_COUNT, count_value);
    write_reg(CFG_INTERVAL, interval_value);
    for (int i = 0; i < NUM_RECTS; i++) write_reg(CFG_RECT_FIRST + CFG_IDX_W'(i), random_rect());
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    cur_time = TIME_W'($urandom_range(31'h7000_0000));
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(4) == 0 || active_regions() == 0) begin
        if ($urandom_range(3) == 0) cur_time = TIME_W'($urandom);
        send_gaze(COORD_W'($urandom), COORD_W'($urandom), cur_time);
        sent++;
      end else begin
        r = int'($urandom_range(active_regions() - 1));
        run_len = $urandom_range(1, 4);
        cur_time += TIME_W'(interval_cfg) + 31'd1 + TIME_W'($urandom_range(500));
        for (int j = 0; j < run_len && sent < n_items; j++) begin
          point_in_rect(r, x, y);
          send_gaze(x, y, cur_time);
          sent++;
          cur_time += TIME_W'($urandom_range(interval_cfg));
        end
      end
    end
  endtask

  // The output is held off while samples keep coming, so the store fills
  // and the input stalls behind a pending packet.
  task automatic test_output_backpressure();
    wait_idle();
    write_reg(CFG_REGION_COUNT, 64'd2);
    write_reg(CFG_INTERVAL, 64'd5);
    write_reg(CFG_RECT_FIRST + 4'd0, make_rect(0, 0, 16'h7FFF, 65535));
    write_reg(CFG_RECT_FIRST + 4'd1, make_rect(16'h8000, 0, 65535, 65535));
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_cycles   <= 400;
    cur_time = 31'd100;
    for (int k = 0; k < 45; k++) begin
      send_gaze({k[0], 15'($urandom)}, COORD_W'($urandom), cur_time);
      cur_time += 31'd10;
    end
  endtask

  initial begin
    region_count_cfg = '0;
    interval_cfg     = INTERVAL_RESET;
    for (int i = 0; i < NUM_RECTS; i++) rect_cfg[i] = '0;
    stored_count = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_directed_cases();
    test_random_phase(0, 0, 20, 64'd6, 64'd1);
    test_random_phase(48, 0, 20, 64'd7, 64'd65535);
    test_random_phase(0, 48, 20, 64'd3, 64'd0);
    test_random_phase(37, 37, 20, 64'd5, 64'($urandom_range(1, 65535)));
    test_output_backpressure();
    wait_idle();
    repeat (20) @(posedge clk_i);
    if (mismatches == 0 && expected_runs.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

// File: gaze_roi_run_packetizer_top.f
rtl/core/gzrp_pkg.sv
rtl/core/gzrp_ram.sv
rtl/core/gzrp_ctrl.sv
rtl/core/gzrp_datapath.sv
rtl/core/gaze_roi_run_packetizer_top.sv
tb/tb.sv
